FILE: rtl/integer_field_formatter_core_defines.svh
// Assertion macros used by the formatter checker file.
`ifndef INTEGER_FIELD_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_CORE_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define IFF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define IFF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/iff_pkg.sv
// Types, constants and helpers shared by the integer field formatter.
package iff_pkg;

  localparam int unsigned MaxWidthDefault = 32;
  localparam int unsigned ValueW          = 32;
  localparam int unsigned FieldWidthW     = 6;
  localparam int unsigned NumDecDigits    = 10;
  localparam int unsigned NumHexDigits    = 8;
  localparam int unsigned DigitsW         = 4 * NumDecDigits;
  localparam int unsigned NdigW           = 4;

  localparam logic [1:0] KindSdec = 2'd0;
  localparam logic [1:0] KindUdec = 2'd1;
  localparam logic [1:0] KindHex  = 2'd2;
  localparam logic [1:0] KindChar = 2'd3;

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharMinus  = 8'h2d;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharALower = 8'h61;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [ValueW-1:0]      value;
    logic [FieldWidthW-1:0] field_width;
    logic                   zero_pad;
  } iff_in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } iff_out_t;

  typedef struct packed {
    logic                   is_char;
    logic                   neg;
    logic                   zero_pad;
    logic [FieldWidthW-1:0] width;
    logic [7:0]             char_byte;
    logic [DigitsW-1:0]     digits;
    logic [NdigW-1:0]       ndig;
  } iff_load_t;

  function automatic logic [7:0] digit_char(logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CharZero + {4'b0, d};
    end else begin
      c = CharALower + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

FILE: rtl/iff_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
module iff_bcd_conv (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [iff_pkg::ValueW-1:0]      mag_i,
  output logic                            done_o,
  output logic [iff_pkg::DigitsW-1:0]     bcd_o
);

  localparam int unsigned CntW = $clog2(iff_pkg::ValueW);

  logic [iff_pkg::ValueW-1:0]  bin_q, bin_d;
  logic [iff_pkg::DigitsW-1:0] bcd_q, bcd_d, adj;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;

  always_comb begin
    for (int i = 0; i < iff_pkg::NumDecDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = mag_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {adj[iff_pkg::DigitsW-2:0], bin_q[iff_pkg::ValueW-1]};
      bin_d = {bin_q[iff_pkg::ValueW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(iff_pkg::ValueW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

FILE: rtl/iff_emitter.sv
// Leading-zero strip, padding and character-serial output of one field.
module iff_emitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  iff_pkg::iff_load_t  load_data_i,
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output iff_pkg::iff_out_t   out_data_o
);

  logic                                active_q, active_d;
  logic                                norm_q, norm_d;
  logic                                sign_q, sign_d;
  logic                                out_valid_q, out_valid_d;
  logic                                zpad_q, zpad_d;
  logic                                is_char_q, is_char_d;
  logic [iff_pkg::FieldWidthW-1:0]     width_q, width_d;
  logic [iff_pkg::FieldWidthW-1:0]     pad_left_q, pad_left_d;
  logic [iff_pkg::NdigW-1:0]           dig_left_q, dig_left_d;
  logic [iff_pkg::DigitsW-1:0]         digits_q, digits_d;
  logic [7:0]                          char_q, char_d;
  iff_pkg::iff_out_t                   out_data_q, out_data_d;
  logic [3:0]                          top_nib;
  logic [iff_pkg::NdigW-1:0]           total;
  logic [iff_pkg::FieldWidthW-1:0]     npad;
  logic                                out_free;
  logic                                emit;

  assign top_nib  = digits_q[iff_pkg::DigitsW-1 -: 4];
  assign total    = dig_left_q + iff_pkg::NdigW'(sign_q);
  assign npad     = (width_q > iff_pkg::FieldWidthW'(total))
                  ? width_q - iff_pkg::FieldWidthW'(total) : '0;
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = active_q && !norm_q && out_free;

  always_comb begin
    active_d    = active_q;
    norm_d      = norm_q;
    sign_d      = sign_q;
    zpad_d      = zpad_q;
    is_char_d   = is_char_q;
    width_d     = width_q;
    pad_left_d  = pad_left_q;
    dig_left_d  = dig_left_q;
    digits_d    = digits_q;
    char_d      = char_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (load_i) begin
      active_d   = 1'b1;
      norm_d     = 1'b1;
      sign_d     = load_data_i.neg;
      zpad_d     = load_data_i.zero_pad;
      is_char_d  = load_data_i.is_char;
      width_d    = load_data_i.width;
      dig_left_d = load_data_i.ndig;
      digits_d   = load_data_i.digits;
      char_d     = load_data_i.char_byte;
    end else if (active_q && norm_q) begin
      if (dig_left_q > iff_pkg::NdigW'(1) && top_nib == 4'd0) begin
        digits_d   = {digits_q[iff_pkg::DigitsW-5:0], 4'd0};
        dig_left_d = dig_left_q - 1'b1;
      end else begin
        norm_d     = 1'b0;
        pad_left_d = npad;
      end
    end else if (emit) begin
      out_valid_d     = 1'b1;
      out_data_d.last = 1'b0;
      if (sign_q && zpad_q) begin
        out_data_d.char_code = iff_pkg::CharMinus;
        sign_d               = 1'b0;
      end else if (pad_left_q != '0) begin
        out_data_d.char_code = zpad_q ? iff_pkg::CharZero : iff_pkg::CharSpace;
        pad_left_d           = pad_left_q - 1'b1;
      end else if (sign_q) begin
        out_data_d.char_code = iff_pkg::CharMinus;
        sign_d               = 1'b0;
      end else begin
        out_data_d.char_code = is_char_q ? char_q : iff_pkg::digit_char(top_nib);
        digits_d             = {digits_q[iff_pkg::DigitsW-5:0], 4'd0};
        dig_left_d           = dig_left_q - 1'b1;
        if (dig_left_q == iff_pkg::NdigW'(1)) begin
          out_data_d.last = 1'b1;
          active_d        = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      norm_q      <= 1'b0;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pad_left_q  <= '0;
      dig_left_q  <= '0;
    end else begin
      active_q    <= active_d;
      norm_q      <= norm_d;
      sign_q      <= sign_d;
      out_valid_q <= out_valid_d;
      pad_left_q  <= pad_left_d;
      dig_left_q  <= dig_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zpad_q     <= zpad_d;
    is_char_q  <= is_char_d;
    width_q    <= width_d;
    digits_q   <= digits_d;
    char_q     <= char_d;
    out_data_q <= out_data_d;
  end

  assign busy_o      = active_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/integer_field_formatter_core.sv
// Decimal items go through BCD conversion, emitter load and zero strip before the first char.
// Hex and character items load the emitter on accept, then zero strip, before the first char.
// After that one char per unstalled cycle; an item yields max(field length, width) chars.
// One item at a time: the next item is taken once the emitter and state machine are idle again.
// Decimal rate is set by the bit-serial BCD converter; output rate by the one-char output port.
// Reset (rst_ni low, asynchronous) empties the output register and returns to idle.
module integer_field_formatter_core #(
  parameter int unsigned MAX_WIDTH = iff_pkg::MaxWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  iff_pkg::iff_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output iff_pkg::iff_out_t out_data_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic                            neg_q, neg_d;
  logic                            zpad_q, zpad_d;
  logic [iff_pkg::FieldWidthW-1:0] width_q, width_d;
  logic                            in_acc;
  logic                            is_dec;
  logic                            neg_in;
  logic [iff_pkg::ValueW-1:0]      mag;
  logic [iff_pkg::FieldWidthW-1:0] width_sat;
  logic                            conv_start;
  logic                            conv_done;
  logic [iff_pkg::DigitsW-1:0]     bcd;
  logic                            load;
  iff_pkg::iff_load_t              load_data;
  logic                            emit_busy;

  assign in_acc     = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);
  assign is_dec     = in_data_i.req_type inside {iff_pkg::KindSdec, iff_pkg::KindUdec};
  assign neg_in     = (in_data_i.req_type == iff_pkg::KindSdec)
                   && in_data_i.value[iff_pkg::ValueW-1];
  assign mag        = neg_in ? (~in_data_i.value + 1'b1) : in_data_i.value;
  assign width_sat  = (32'(in_data_i.field_width) > 32'(MAX_WIDTH))
                    ? iff_pkg::FieldWidthW'(MAX_WIDTH) : in_data_i.field_width;
  assign conv_start = in_acc && is_dec;
  assign load       = (in_acc && !is_dec) || ((state_q == StConv) && conv_done);

  always_comb begin
    if (state_q == StConv) begin
      load_data.is_char   = 1'b0;
      load_data.neg       = neg_q;
      load_data.zero_pad  = zpad_q;
      load_data.width     = width_q;
      load_data.char_byte = '0;
      load_data.digits    = bcd;
      load_data.ndig      = iff_pkg::NdigW'(iff_pkg::NumDecDigits);
    end else begin
      load_data.is_char   = (in_data_i.req_type == iff_pkg::KindChar);
      load_data.neg       = 1'b0;
      load_data.zero_pad  = in_data_i.zero_pad;
      load_data.width     = width_sat;
      load_data.char_byte = in_data_i.value[7:0];
      load_data.digits    = {in_data_i.value,
                             {(iff_pkg::DigitsW - iff_pkg::ValueW){1'b0}}};
      load_data.ndig      = (in_data_i.req_type == iff_pkg::KindChar)
                          ? iff_pkg::NdigW'(1) : iff_pkg::NdigW'(iff_pkg::NumHexDigits);
    end
  end

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    zpad_d  = zpad_q;
    width_d = width_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          neg_d   = neg_in;
          zpad_d  = in_data_i.zero_pad;
          width_d = width_sat;
          state_d = is_dec ? StConv : StEmit;
        end
      end
      StConv: begin
        if (conv_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!emit_busy) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    zpad_q  <= zpad_d;
    width_q <= width_d;
  end

  iff_bcd_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .mag_i   (mag),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  iff_emitter u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .load_data_i (load_data),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/iff_checker.sv
// Port-level checker for the integer field formatter, bound to the top level.
`include "integer_field_formatter_core_defines.svh"

module iff_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_i,
  input logic              out_valid_i,
  input logic              out_stall_i,
  input iff_pkg::iff_out_t out_data_i
);

  `IFF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i), "stalled output item changed")
  `IFF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_i, in_stall_i, "input not stalled after an accepted item")
  `IFF_ASSERT_SAME(a_idle_only_last, clk_i, rst_ni, !in_stall_i && out_valid_i, out_data_i.last, "ready for input while a field is unfinished")
  `IFF_ASSERT_NEXT(a_chars_back_to_back, clk_i, rst_ni, out_valid_i && !out_stall_i && !out_data_i.last, out_valid_i, "gap inside a field")

endmodule

bind integer_field_formatter_core iff_checker u_iff_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

FILE: test/testbench.sv
// Testbench for integer_field_formatter_core: random and directed fields checked per character.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    iff_pkg::iff_in_t req;
    bit               drain;
  } request_t;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainHold     = 60;
  localparam int unsigned EndHold       = 100;
  localparam int unsigned MaxReports    = 10;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  iff_pkg::iff_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  iff_pkg::iff_out_t out_data;

  request_t          pending_reqs[$];
  iff_pkg::iff_out_t expected_chars[$];
  logic              chars_drained;
  int                fail_count;
  int                idle_cycles;
  int                burst_left;
  int                gap_left;
  int                hold_cnt;
  int                stall_mode;
  int                mode_left;

  integer_field_formatter_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void format_field(iff_pkg::iff_in_t req);
    logic [7:0]        digits_rev[$];
    logic [31:0]       mag;
    logic [31:0]       base;
    logic [31:0]       d;
    logic [7:0]        pad_char;
    logic [7:0]        field[$];
    logic              neg;
    int                width;
    int                npad;
    iff_pkg::iff_out_t ch;
    neg = 1'b0;
    mag = req.value;
    width = (req.field_width > iff_pkg::MaxWidthDefault)
          ? int'(iff_pkg::MaxWidthDefault) : int'(req.field_width);
    pad_char = req.zero_pad ? iff_pkg::CharZero : iff_pkg::CharSpace;
    base = (req.req_type == iff_pkg::KindHex) ? 32'd16 : 32'd10;
    if (req.req_type == iff_pkg::KindChar) begin
      digits_rev.push_back(req.value[7:0]);
    end else begin
      if (req.req_type == iff_pkg::KindSdec && req.value[31]) begin
        neg = 1'b1;
        mag = 32'd0 - req.value;
      end
      do begin
        d = mag % base;
        mag = mag / base;
        digits_rev.push_back((d < 32'd10) ? iff_pkg::CharZero + d[7:0]
                                          : iff_pkg::CharALower + d[7:0] - 8'd10);
      end while (mag != 32'd0);
    end
    npad = width - int'(digits_rev.size()) - int'(neg);
    if (npad < 0) npad = 0;
    if (neg && req.zero_pad) field.push_back(iff_pkg::CharMinus);
    for (int i = 0; i < npad; i++) field.push_back(pad_char);
    if (neg && !req.zero_pad) field.push_back(iff_pkg::CharMinus);
    for (int i = int'(digits_rev.size()) - 1; i >= 0; i--) field.push_back(digits_rev[i]);
    for (int i = 0; i < field.size(); i++) begin
      ch.char_code = field[i];
      ch.last = (i == field.size() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  task automatic add_request(input logic [1:0] kind, input logic [31:0] value,
                             input logic [5:0] width, input bit pad, input bit drain);
    request_t r;
    r.req.req_type = kind;
    r.req.value = value;
    r.req.field_width = width;
    r.req.zero_pad = pad;
    r.drain = drain;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 20);
      1: v = $urandom;
      2: v = 32'h8000_0000 | $urandom;
      3: v = 32'd0 - $urandom_range(1, 1000);
      4: v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
      default: v = $urandom_range(0, 99999);
    endcase
    return v;
  endfunction

  function automatic logic [5:0] pick_width();
    logic [5:0] w;
    case ($urandom_range(0, 9))
      0: w = 6'($urandom_range(0, 63));
      1, 2, 3: w = 6'($urandom_range(0, 32));
      default: w = 6'($urandom_range(0, 12));
    endcase
    return w;
  endfunction

  // Sender: bursts with gaps; a drain request waits for all results, then holds off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left = $urandom_range(1, 12);
      gap_left = 0;
      hold_cnt = 0;
    end else if (!in_valid || !in_stall) begin
      if (hold_cnt > 0) begin
        hold_cnt--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 && pending_reqs[0].drain) begin
        in_valid <= 1'b0;
        if (!in_valid && chars_drained) begin
          pending_reqs[0].drain = 1'b0;
          hold_cnt = DrainHold;
        end
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_data <= pending_reqs[0].req;
        in_valid <= 1'b1;
        pending_reqs.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // Receiver: stall pattern changes mode every so often.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_mode = 0;
      mode_left = 0;
    end else begin
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      out_stall <= (stall_mode == 0) ? 1'b0 : ($urandom_range(0, 3) < stall_mode);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) format_field(in_data);
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          if (fail_count < MaxReports) begin
            $display("unexpected item: char %h last %b", out_data.char_code, out_data.last);
          end
          fail_count++;
        end else begin
          if (out_data.char_code !== expected_chars[0].char_code ||
              out_data.last !== expected_chars[0].last) begin
            if (fail_count < MaxReports) begin
              $display("mismatch: expected char %h last %b, got char %h last %b",
                       expected_chars[0].char_code, expected_chars[0].last,
                       out_data.char_code, out_data.last);
            end
            fail_count++;
          end
          expected_chars.pop_front();
        end
      end
      chars_drained <= (expected_chars.size() == 0);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    fail_count = 0;
    idle_cycles = 0;
    chars_drained = 1'b1;
    add_request(iff_pkg::KindSdec, 32'd0, 6'd0, 1'b0, 1'b0);
    add_request(iff_pkg::KindSdec, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0);
    add_request(iff_pkg::KindSdec, 32'h8000_0000, 6'd0, 1'b0, 1'b0);
    add_request(iff_pkg::KindSdec, 32'h8000_0000, 6'd32, 1'b1, 1'b0);
    add_request(iff_pkg::KindSdec, 32'd0 - 32'd42, 6'd8, 1'b1, 1'b0);
    add_request(iff_pkg::KindSdec, 32'd0 - 32'd42, 6'd8, 1'b0, 1'b0);
    add_request(iff_pkg::KindSdec, 32'h7FFF_FFFF, 6'd5, 1'b0, 1'b0);
    add_request(iff_pkg::KindSdec, 32'd5, 6'd1, 1'b1, 1'b0);
    add_request(iff_pkg::KindSdec, 32'hFFFF_FFFF, 6'd2, 1'b1, 1'b0);
    add_request(iff_pkg::KindUdec, 32'd0, 6'd1, 1'b0, 1'b0);
    add_request(iff_pkg::KindUdec, 32'hFFFF_FFFF, 6'd12, 1'b1, 1'b0);
    add_request(iff_pkg::KindUdec, 32'd7, 6'd63, 1'b0, 1'b0);
    add_request(iff_pkg::KindUdec, 32'd1234567890, 6'd0, 1'b0, 1'b0);
    add_request(iff_pkg::KindHex, 32'd0, 6'd0, 1'b0, 1'b0);
    add_request(iff_pkg::KindHex, 32'hFFFF_FFFF, 6'd10, 1'b1, 1'b0);
    add_request(iff_pkg::KindHex, 32'hDEAD_BEEF, 6'd33, 1'b0, 1'b0);
    add_request(iff_pkg::KindHex, 32'h0000_ABCD, 6'd3, 1'b0, 1'b0);
    add_request(iff_pkg::KindChar, 32'h0000_0041, 6'd0, 1'b0, 1'b0);
    add_request(iff_pkg::KindChar, 32'h0000_0000, 6'd4, 1'b1, 1'b0);
    add_request(iff_pkg::KindChar, 32'hFFFF_FF7A, 6'd32, 1'b0, 1'b0);
    add_request(iff_pkg::KindChar, 32'h0000_00FF, 6'd63, 1'b1, 1'b0);
    add_request(iff_pkg::KindUdec, 32'h8000_0000, 6'd40, 1'b1, 1'b0);
    for (int i = 0; i < 348; i++) begin
      add_request(2'($urandom_range(0, 3)), pick_value(), pick_width(),
                  1'($urandom_range(0, 1)), (i == 120 || i == 260));
    end
    @(posedge rst_ni);
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_reqs.size() != 0 || in_valid);
    while (expected_chars.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (EndHold) @(posedge clk_i);
    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
